/* hdl/hmpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hmpq_pkg;

	// Field widths fixed by the command and result beats
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 6;
	localparam int COUNT_W  = 7;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT  = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_DROP = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_BAD   = 2'd3
	} stat_t;

	// Step applied to the sorted entry chain
	typedef enum logic [1:0] {
		EOP_HOLD,
		EOP_INSERT,
		EOP_REMOVE
	} eop_t;

	// Step applied to the free-handle chain
	typedef enum logic [1:0] {
		FOP_HOLD,
		FOP_TAKE,
		FOP_GIVE
	} fop_t;

endpackage

`default_nettype wire

/* hdl/hmpq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/hmpq_entry_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmpq_entry_cell #(
	parameter int AW = 6
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire hmpq_pkg::eop_t                       op,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    bc_key,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    bc_x,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    bc_y,
	input  wire logic        [AW-1:0]                 bc_h,
	input  wire logic                                 prev_valid,
	input  wire logic                                 prev_before,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    prev_key,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    prev_x,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    prev_y,
	input  wire logic        [AW-1:0]                 prev_h,
	input  wire logic                                 next_valid,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    next_key,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    next_x,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]    next_y,
	input  wire logic        [AW-1:0]                 next_h,
	output logic                                      valid,
	output logic                                      behind,
	output logic signed      [hmpq_pkg::KEY_W-1:0]    key,
	output logic signed      [hmpq_pkg::KEY_W-1:0]    x,
	output logic signed      [hmpq_pkg::KEY_W-1:0]    y,
	output logic             [AW-1:0]                 h
);

	import hmpq_pkg::*;

	logic ahead;
	logic valid_d;
	logic signed [KEY_W-1:0] key_d, x_d, y_d;
	logic [AW-1:0] h_d;

	// Order: larger key first, lower handle first among equal keys
	assign ahead  = valid && ((key > bc_key) || ((key == bc_key) && (h < bc_h)));
	assign behind = !ahead;

	// Pick this cell's next content from its neighbors or the broadcast
	always_comb begin
		valid_d = valid;
		key_d   = key;
		x_d     = x;
		y_d     = y;
		h_d     = h;
		unique case (op)
			EOP_HOLD: begin
			end
			EOP_INSERT: begin
				if (!ahead) begin
					if (prev_before) begin
						valid_d = prev_valid;
						key_d   = prev_key;
						x_d     = prev_x;
						y_d     = prev_y;
						h_d     = prev_h;
					end else begin
						valid_d = 1'b1;
						key_d   = bc_key;
						x_d     = bc_x;
						y_d     = bc_y;
						h_d     = bc_h;
					end
				end
			end
			EOP_REMOVE: begin
				if (!ahead) begin
					valid_d = next_valid;
					key_d   = next_key;
					x_d     = next_x;
					y_d     = next_y;
					h_d     = next_h;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key <= key_d;
		x   <= x_d;
		y   <= y_d;
		h   <= h_d;
	end

endmodule

`default_nettype wire

/* hdl/hmpq_free_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module hmpq_free_cell #(
	parameter int AW    = 6,
	parameter int INDEX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hmpq_pkg::fop_t op,
	input  wire logic [AW-1:0] bc_h,
	input  wire logic          prev_valid,
	input  wire logic          prev_before,
	input  wire logic [AW-1:0] prev_h,
	input  wire logic          next_valid,
	input  wire logic [AW-1:0] next_h,
	output logic               valid,
	output logic               behind,
	output logic      [AW-1:0] h
);

	import hmpq_pkg::*;

	// Free handles are kept in ascending order, lowest at the head
	assign behind = !valid || (bc_h < h);

	// Shift out the head, or slot a returned handle into place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b1;
			h     <= AW'(INDEX);
		end else begin
			unique case (op)
				FOP_HOLD: begin
				end
				FOP_TAKE: begin
					valid <= next_valid;
					h     <= next_h;
				end
				FOP_GIVE: begin
					if (behind) begin
						if (prev_before) begin
							valid <= prev_valid;
							h     <= prev_h;
						end else begin
							valid <= 1'b1;
							h     <= bc_h;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/handle_max_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Addressable max-priority queue of DEPTH entries. A command beat is taken when start is
// high and busy is low; exactly one result beat follows, marked by done for one cycle, and
// it cannot be held off, so the receiver must capture it in that cycle. Insert, pop, peek,
// remove and every error case are decided in the S_DECIDE state that follows acceptance (busy
// stays high while it is decided), since the front of the sorted chain of cells and the free
// handle chain are read directly and a whole chain shifts at once at any depth.
// Update also passes through S_UPDATE: the old entry is first shifted out of the chain, using its key
// read from the key RAM, and the new one shifted in on the next cycle. Keys are signed
// Q16.16; the largest key is served first and the lowest handle wins a tie.
module handle_max_priority_queue #(
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic        [hmpq_pkg::CMD_W-1:0]     command,
	input  wire logic                                  has_handle,
	input  wire logic        [hmpq_pkg::HANDLE_W-1:0]  slot_handle,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]     sweep_key,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]     site_x,
	input  wire logic signed [hmpq_pkg::KEY_W-1:0]     site_y,
	output logic                                       done,
	output logic             [hmpq_pkg::HANDLE_W-1:0]  out_handle,
	output logic signed      [hmpq_pkg::KEY_W-1:0]     out_key,
	output logic signed      [hmpq_pkg::KEY_W-1:0]     out_x,
	output logic signed      [hmpq_pkg::KEY_W-1:0]     out_y,
	output logic             [hmpq_pkg::STAT_W-1:0]    status,
	output logic             [hmpq_pkg::COUNT_W-1:0]   entry_count
);

	import hmpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HX = AW + HANDLE_W;
	localparam int OX = CW + COUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_UPDATE
	} st_t;

	st_t state_q, state_d;

	// Captured command beat
	cmd_t cmd_q;
	logic has_q;
	logic [HANDLE_W-1:0] handle_q;
	logic signed [KEY_W-1:0] key_q, x_q, y_q;

	logic [DEPTH-1:0] in_use_q;
	logic [CW-1:0] occ_q, occ_d;

	// Chain cells, with one tied-off entry past the tail
	logic                    e_valid  [DEPTH+1];
	logic                    e_before [DEPTH];
	logic signed [KEY_W-1:0] e_key    [DEPTH+1];
	logic signed [KEY_W-1:0] e_x      [DEPTH+1];
	logic signed [KEY_W-1:0] e_y      [DEPTH+1];
	logic [AW-1:0]           e_h      [DEPTH+1];
	logic                    f_valid  [DEPTH+1];
	logic                    f_before [DEPTH];
	logic [AW-1:0]           f_h      [DEPTH+1];

	eop_t eop;
	fop_t fop;
	logic signed [KEY_W-1:0] bc_key;
	logic [AW-1:0] bc_h, fbc_h;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	logic [HX-1:0] in_wide, hq_wide, res_wide;
	logic [AW-1:0] h_idx;
	logic in_range, live;

	logic fin, use_set, use_clr;
	logic [AW-1:0] use_idx, res_h;
	stat_t res_stat;
	logic signed [KEY_W-1:0] res_key, res_x, res_y;
	logic [OX-1:0] cnt_wide;

	assign busy = (state_q != S_IDLE);

	// Fit the 6-bit handle to the slot index width
	assign in_wide   = {{AW{1'b0}}, slot_handle};
	assign ram_raddr = in_wide[AW-1:0];
	assign ram_re    = start && !busy;
	assign hq_wide   = {{AW{1'b0}}, handle_q};
	assign h_idx     = hq_wide[AW-1:0];
	assign in_range  = hq_wide < HX'(DEPTH);
	assign live      = in_range && in_use_q[h_idx];

	hmpq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(key_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Tie off the cells past the tail
	assign e_valid[DEPTH] = 1'b0;
	assign e_key[DEPTH]   = '0;
	assign e_x[DEPTH]     = '0;
	assign e_y[DEPTH]     = '0;
	assign e_h[DEPTH]     = '0;
	assign f_valid[DEPTH] = 1'b0;
	assign f_h[DEPTH]     = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    p_valid, p_before, pf_valid, pf_before;
		logic signed [KEY_W-1:0] p_key, p_x, p_y;
		logic [AW-1:0]           p_h, pf_h;

		if (i == 0) begin : g_head
			assign p_valid   = 1'b0;
			assign p_before  = 1'b0;
			assign p_key     = '0;
			assign p_x       = '0;
			assign p_y       = '0;
			assign p_h       = '0;
			assign pf_valid  = 1'b0;
			assign pf_before = 1'b0;
			assign pf_h      = '0;
		end else begin : g_body
			assign p_valid   = e_valid[i-1];
			assign p_before  = e_before[i-1];
			assign p_key     = e_key[i-1];
			assign p_x       = e_x[i-1];
			assign p_y       = e_y[i-1];
			assign p_h       = e_h[i-1];
			assign pf_valid  = f_valid[i-1];
			assign pf_before = f_before[i-1];
			assign pf_h      = f_h[i-1];
		end

		hmpq_entry_cell #(
			.AW(AW)
		) u_entry (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (eop),
			.bc_key     (bc_key),
			.bc_x       (x_q),
			.bc_y       (y_q),
			.bc_h       (bc_h),
			.prev_valid (p_valid),
			.prev_before(p_before),
			.prev_key   (p_key),
			.prev_x     (p_x),
			.prev_y     (p_y),
			.prev_h     (p_h),
			.next_valid (e_valid[i+1]),
			.next_key   (e_key[i+1]),
			.next_x     (e_x[i+1]),
			.next_y     (e_y[i+1]),
			.next_h     (e_h[i+1]),
			.valid      (e_valid[i]),
			.behind     (e_before[i]),
			.key        (e_key[i]),
			.x          (e_x[i]),
			.y          (e_y[i]),
			.h          (e_h[i])
		);

		hmpq_free_cell #(
			.AW   (AW),
			.INDEX(i)
		) u_free (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (fop),
			.bc_h       (fbc_h),
			.prev_valid (pf_valid),
			.prev_before(pf_before),
			.prev_h     (pf_h),
			.next_valid (f_valid[i+1]),
			.next_h     (f_h[i+1]),
			.valid      (f_valid[i]),
			.behind     (f_before[i]),
			.h          (f_h[i])
		);
	end

	// Decide the command and drive the chain steps
	always_comb begin
		state_d   = state_q;
		eop       = EOP_HOLD;
		fop       = FOP_HOLD;
		bc_key    = key_q;
		bc_h      = h_idx;
		fbc_h     = h_idx;
		ram_we    = 1'b0;
		ram_waddr = h_idx;
		fin       = 1'b0;
		res_stat  = STAT_OK;
		res_h     = '0;
		res_key   = '0;
		res_x     = '0;
		res_y     = '0;
		occ_d     = occ_q;
		use_set   = 1'b0;
		use_clr   = 1'b0;
		use_idx   = h_idx;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				unique case (cmd_q)
					CMD_PUT: begin
						if (has_q) begin
							if (live) begin
								// Shift the old entry out first
								eop     = EOP_REMOVE;
								bc_key  = $signed(ram_rdata);
								fin     = 1'b0;
								state_d = S_UPDATE;
							end else begin
								res_stat = STAT_BAD;
							end
						end else if (!f_valid[0]) begin
							res_stat = STAT_FULL;
						end else begin
							eop       = EOP_INSERT;
							bc_h      = f_h[0];
							fop       = FOP_TAKE;
							ram_we    = 1'b1;
							ram_waddr = f_h[0];
							use_set   = 1'b1;
							use_idx   = f_h[0];
							occ_d     = occ_q + CW'(1);
							res_h     = f_h[0];
						end
					end
					CMD_POP, CMD_PEEK: begin
						if (!e_valid[0]) begin
							res_stat = STAT_EMPTY;
						end else begin
							res_h   = e_h[0];
							res_key = e_key[0];
							res_x   = e_x[0];
							res_y   = e_y[0];
							if (cmd_q == CMD_POP) begin
								eop     = EOP_REMOVE;
								bc_key  = e_key[0];
								bc_h    = e_h[0];
								fop     = FOP_GIVE;
								fbc_h   = e_h[0];
								use_clr = 1'b1;
								use_idx = e_h[0];
								occ_d   = occ_q - CW'(1);
							end
						end
					end
					CMD_DROP: begin
						if (live) begin
							eop     = EOP_REMOVE;
							bc_key  = $signed(ram_rdata);
							fop     = FOP_GIVE;
							use_clr = 1'b1;
							occ_d   = occ_q - CW'(1);
							res_h   = h_idx;
						end else begin
							res_stat = STAT_BAD;
						end
					end
					default: begin
					end
				endcase
			end
			S_UPDATE: begin
				// Shift the rewritten entry back in
				eop     = EOP_INSERT;
				ram_we  = 1'b1;
				fin     = 1'b1;
				res_h   = h_idx;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_wide = {{HANDLE_W{1'b0}}, res_h};
	assign cnt_wide = {{COUNT_W{1'b0}}, occ_d};

	// Hold state, occupancy, slot map and the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			in_use_q    <= '0;
			done        <= 1'b0;
			out_handle  <= '0;
			out_key     <= '0;
			out_x       <= '0;
			out_y       <= '0;
			status      <= '0;
			entry_count <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (use_set) begin
				in_use_q[use_idx] <= 1'b1;
			end
			if (use_clr) begin
				in_use_q[use_idx] <= 1'b0;
			end
			done <= fin;
			if (fin) begin
				out_handle  <= res_wide[HANDLE_W-1:0];
				out_key     <= res_key;
				out_x       <= res_x;
				out_y       <= res_y;
				status      <= res_stat;
				entry_count <= cnt_wide[COUNT_W-1:0];
			end
		end
	end

	// Capture the command beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q    <= cmd_t'(command);
			has_q    <= has_handle;
			handle_q <= slot_handle;
			key_q    <= sweep_key;
			x_q      <= site_x;
			y_q      <= site_y;
		end
	end

	// The entry being updated is out of the chain while in S_UPDATE
	a_front_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_UPDATE) |-> (e_valid[0] == (occ_q != '0)))
		else $error("front cell validity disagrees with occupancy");

	a_free_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid[0] == (occ_q != CW'(DEPTH)))
		else $error("free chain head disagrees with occupancy");

	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid[1] |-> e_valid[0])
		else $error("entry chain has a hole at the front");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in progress");

	a_accept_decides: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECIDE))
		else $error("accepted command not decided next cycle");

endmodule

`default_nettype wire

/* test/handle_max_priority_queue_test.sv */
`timescale 1ns / 1ps

module handle_max_priority_queue_test;

	import hmpq_pkg::*;

	localparam int SLOTS        = 64;
	localparam int RANDOM_BEATS = 2000;
	localparam int CALM_BEATS   = 300;
	localparam int SEGMENT      = 100;
	localparam int CYCLE_LIMIT  = 100000;

	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fffffff;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h80000000;

	// Bias of the random command mix
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_BLEND = 2;

	typedef struct packed {
		cmd_t                      cmd;
		logic                      has_handle;
		logic [HANDLE_W-1:0]       handle;
		logic signed [KEY_W-1:0]   key;
		logic signed [KEY_W-1:0]   x;
		logic signed [KEY_W-1:0]   y;
	} cmd_beat_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]       handle;
		logic signed [KEY_W-1:0]   key;
		logic signed [KEY_W-1:0]   x;
		logic signed [KEY_W-1:0]   y;
		stat_t                     status;
		logic [COUNT_W-1:0]        count;
	} queue_result_t;

	typedef struct packed {
		cmd_beat_t                 beat;
		logic                      pinned;
		queue_result_t             want;
	} plan_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [CMD_W-1:0]            command = '0;
	logic                        has_handle = 1'b0;
	logic [HANDLE_W-1:0]         slot_handle = '0;
	logic signed [KEY_W-1:0]     sweep_key = '0;
	logic signed [KEY_W-1:0]     site_x = '0;
	logic signed [KEY_W-1:0]     site_y = '0;
	logic                        done;
	logic [HANDLE_W-1:0]         out_handle;
	logic signed [KEY_W-1:0]     out_key;
	logic signed [KEY_W-1:0]     out_x;
	logic signed [KEY_W-1:0]     out_y;
	logic [STAT_W-1:0]           status;
	logic [COUNT_W-1:0]          entry_count;

	// Typed-in expectation that travels with the command beat
	logic                        pin_valid = 1'b0;
	queue_result_t               pin_want = '0;

	handle_max_priority_queue #(
		.DEPTH(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.has_handle(has_handle),
		.slot_handle(slot_handle),
		.sweep_key(sweep_key),
		.site_x(site_x),
		.site_y(site_y),
		.done(done),
		.out_handle(out_handle),
		.out_key(out_key),
		.out_x(out_x),
		.out_y(out_y),
		.status(status),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	// Shadow of the queue contents
	logic signed [KEY_W-1:0]     shadow_key [SLOTS];
	logic signed [KEY_W-1:0]     shadow_x [SLOTS];
	logic signed [KEY_W-1:0]     shadow_y [SLOTS];
	logic                        shadow_live [SLOTS];
	int                          shadow_fill;

	queue_result_t               pending_results [$];
	plan_row_t                   directed_plan [$];
	int                          mismatches;
	int                          checked;
	int                          cycle_count;
	int                          cmd_seen [4];
	int                          stat_seen [4];
	int                          updates_seen;

	// Apply one command to the shadow queue and return the result beat it causes
	function automatic queue_result_t apply_queue_command(input cmd_beat_t b);
		queue_result_t r;
		int slot;
		r = '0;
		r.status = STAT_OK;
		slot = -1;
		case (b.cmd)
			CMD_PUT: begin
				if (b.has_handle) begin
					if (!shadow_live[b.handle]) begin
						r.status = STAT_BAD;
					end else begin
						slot = b.handle;
					end
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (!shadow_live[i] && slot < 0)
							slot = i;
					if (slot < 0) begin
						r.status = STAT_FULL;
					end else begin
						shadow_live[slot] = 1'b1;
						shadow_fill++;
					end
				end
				if (slot >= 0) begin
					shadow_key[slot] = b.key;
					shadow_x[slot] = b.x;
					shadow_y[slot] = b.y;
					r.handle = slot[HANDLE_W-1:0];
				end
			end
			CMD_POP, CMD_PEEK: begin
				// Largest key wins; strict compare keeps the lowest handle on ties
				for (int i = 0; i < SLOTS; i++)
					if (shadow_live[i] && (slot < 0 || shadow_key[i] > shadow_key[slot]))
						slot = i;
				if (slot < 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.handle = slot[HANDLE_W-1:0];
					r.key = shadow_key[slot];
					r.x = shadow_x[slot];
					r.y = shadow_y[slot];
					if (b.cmd == CMD_POP) begin
						shadow_live[slot] = 1'b0;
						shadow_fill--;
					end
				end
			end
			CMD_DROP: begin
				if (!shadow_live[b.handle]) begin
					r.status = STAT_BAD;
				end else begin
					shadow_live[b.handle] = 1'b0;
					shadow_fill--;
					r.handle = b.handle;
				end
			end
		endcase
		r.count = shadow_fill[COUNT_W-1:0];
		return r;
	endfunction

	function automatic queue_result_t result_of(input logic [HANDLE_W-1:0] h,
			input logic signed [KEY_W-1:0] k, input logic signed [KEY_W-1:0] x,
			input logic signed [KEY_W-1:0] y, input stat_t st, input int n);
		queue_result_t r;
		r.handle = h;
		r.key = k;
		r.x = x;
		r.y = y;
		r.status = st;
		r.count = n[COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_row(input cmd_t c, input logic hh, input logic [HANDLE_W-1:0] h,
			input logic signed [KEY_W-1:0] k, input logic signed [KEY_W-1:0] x,
			input logic signed [KEY_W-1:0] y, input logic pinned, input queue_result_t want);
		plan_row_t row;
		row.beat.cmd = c;
		row.beat.has_handle = hh;
		row.beat.handle = h;
		row.beat.key = k;
		row.beat.x = x;
		row.beat.y = y;
		row.pinned = pinned;
		row.want = want;
		directed_plan.push_back(row);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	// Mix of tie-prone small keys, extremes and fully random words
	function automatic logic signed [KEY_W-1:0] random_word();
		logic [KEY_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = 32'($urandom_range(0, 7)) - 32'd4;
				v = v << 16;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: v = KEY_MAX;
					1: v = KEY_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly a live handle, so that updates and removes get past the handle check
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int base;
		base = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 99) < 85)
			for (int i = 0; i < SLOTS; i++)
				if (shadow_live[(base + i) % SLOTS])
					return HANDLE_W'((base + i) % SLOTS);
		return HANDLE_W'(base);
	endfunction

	function automatic cmd_beat_t random_beat(input int mix);
		cmd_beat_t b;
		int roll;
		int put_cut;
		int upd_cut;
		int pop_cut;
		int peek_cut;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				put_cut = 70; upd_cut = 80; pop_cut = 85; peek_cut = 90;
			end
			MIX_DRAIN: begin
				put_cut = 15; upd_cut = 25; pop_cut = 60; peek_cut = 70;
			end
			default: begin
				put_cut = 35; upd_cut = 50; pop_cut = 70; peek_cut = 80;
			end
		endcase
		b.handle = pick_handle();
		b.has_handle = 1'($urandom_range(0, 1));
		b.key = random_word();
		b.x = random_word();
		b.y = random_word();
		if (roll < put_cut) begin
			b.cmd = CMD_PUT;
			b.has_handle = 1'b0;
			b.handle = HANDLE_W'($urandom_range(0, SLOTS - 1));
		end else if (roll < upd_cut) begin
			b.cmd = CMD_PUT;
			b.has_handle = 1'b1;
		end else if (roll < pop_cut) begin
			b.cmd = CMD_POP;
		end else if (roll < peek_cut) begin
			b.cmd = CMD_PEEK;
		end else begin
			b.cmd = CMD_DROP;
		end
		return b;
	endfunction

	// Present one command beat and hold it until the block takes it
	task automatic send_beat(input cmd_beat_t b, input logic pinned, input queue_result_t want);
		start <= 1'b1;
		command <= b.cmd;
		has_handle <= b.has_handle;
		slot_handle <= b.handle;
		sweep_key <= b.key;
		site_x <= b.x;
		site_y <= b.y;
		pin_valid <= pinned;
		pin_want <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 3)) @(posedge clk);
	endtask

	// Hold off the sender until every expected result beat has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Predict on each accepted command beat, then check any result beat
	always @(posedge clk) begin
		cmd_beat_t b;
		queue_result_t want;
		queue_result_t got;
		if (arst_n) begin
			if (start && !busy) begin
				b.cmd = cmd_t'(command);
				b.has_handle = has_handle;
				b.handle = slot_handle;
				b.key = sweep_key;
				b.x = site_x;
				b.y = site_y;
				want = apply_queue_command(b);
				if (pin_valid)
					want = pin_want;
				pending_results.push_back(want);
				cmd_seen[b.cmd]++;
				stat_seen[want.status]++;
				if (b.cmd == CMD_PUT && b.has_handle)
					updates_seen++;
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with no command outstanding");
				end else begin
					want = pending_results.pop_front();
					got = result_of(out_handle, out_key, out_x, out_y, stat_t'(status),
						int'(entry_count));
					check_field("out_handle", 32'(got.handle), 32'(want.handle));
					check_field("out_key", got.key, want.key);
					check_field("out_x", got.x, want.x);
					check_field("out_y", got.y, want.y);
					check_field("status", 32'(status), 32'(want.status));
					check_field("entry_count", 32'(got.count), 32'(want.count));
					checked++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cmd_beat_t b;
		int mix;
		mismatches = 0;
		checked = 0;
		cycle_count = 0;
		updates_seen = 0;
		shadow_fill = 0;
		for (int i = 0; i < 4; i++) begin
			cmd_seen[i] = 0;
			stat_seen[i] = 0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			shadow_live[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_x[i] = '0;
			shadow_y[i] = '0;
		end

		// Empty queue and unknown handles
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b1, result_of(0, 0, 0, 0, STAT_EMPTY, 0));
		add_row(CMD_PEEK, 1'b1, 6'd63, KEY_MAX, KEY_MAX, KEY_MAX, 1'b1,
			result_of(0, 0, 0, 0, STAT_EMPTY, 0));
		add_row(CMD_DROP, 1'b0, 6'd0, 0, 0, 0, 1'b1, result_of(0, 0, 0, 0, STAT_BAD, 0));
		add_row(CMD_PUT, 1'b1, 6'd63, KEY_MAX, KEY_MIN, KEY_MAX, 1'b1,
			result_of(0, 0, 0, 0, STAT_BAD, 0));
		// Inserts take the lowest free handle
		add_row(CMD_PUT, 1'b0, 6'd63, KEY_MAX, KEY_MIN, KEY_MAX, 1'b1,
			result_of(0, 0, 0, 0, STAT_OK, 1));
		add_row(CMD_PUT, 1'b0, 6'd0, KEY_MIN, KEY_MAX, KEY_MIN, 1'b1,
			result_of(1, 0, 0, 0, STAT_OK, 2));
		add_row(CMD_PUT, 1'b0, 6'd21, 0, -1, 1, 1'b0, '0);
		add_row(CMD_PUT, 1'b0, 6'd42, KEY_MAX, 1, 2, 1'b0, '0);
		// Tie on the top key goes to the lower handle
		add_row(CMD_PEEK, 1'b0, 6'd0, 0, 0, 0, 1'b1,
			result_of(0, KEY_MAX, KEY_MIN, KEY_MAX, STAT_OK, 4));
		add_row(CMD_PUT, 1'b1, 6'd0, -1, 5, 6, 1'b0, '0);
		add_row(CMD_PEEK, 1'b0, 6'd0, 0, 0, 0, 1'b0, '0);
		add_row(CMD_POP, 1'b1, 6'd42, KEY_MIN, 0, 0, 1'b0, '0);
		add_row(CMD_DROP, 1'b0, 6'd1, 0, 0, 0, 1'b0, '0);
		add_row(CMD_DROP, 1'b0, 6'd1, 0, 0, 0, 1'b1, result_of(0, 0, 0, 0, STAT_BAD, 2));
		add_row(CMD_PUT, 1'b1, 6'd1, 7, 7, 7, 1'b1, result_of(0, 0, 0, 0, STAT_BAD, 2));
		// Reused handles, then a tie at the bottom key
		add_row(CMD_PUT, 1'b0, 6'd0, KEY_MIN, 3, 4, 1'b0, '0);
		add_row(CMD_PUT, 1'b0, 6'd0, KEY_MIN, 8, 9, 1'b0, '0);
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b0, '0);
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b0, '0);
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b0, '0);
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b0, '0);
		add_row(CMD_POP, 1'b0, 6'd0, 0, 0, 0, 1'b1, result_of(0, 0, 0, 0, STAT_EMPTY, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_plan[i]) begin
			send_beat(directed_plan[i].beat, directed_plan[i].pinned, directed_plan[i].want);
			if ($urandom_range(0, 4) == 0)
				idle_burst();
		end
		drain_results();

		// Random segments: a fill-biased mix, then a drain-biased mix, then random mixes
		mix = MIX_FILL;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % SEGMENT == 0)
				mix = (n == 0) ? MIX_FILL : (n == SEGMENT) ? MIX_DRAIN : $urandom_range(0, 2);
			if (n == RANDOM_BEATS / 2)
				drain_results();
			b = random_beat(mix);
			send_beat(b, 1'b0, '0);
			if (n < RANDOM_BEATS - CALM_BEATS && $urandom_range(0, 4) == 0)
				idle_burst();
		end

		drain_results();
		repeat (10) @(posedge clk);

		$display("commands: %0d insert/update (%0d updates), %0d pop, %0d peek, %0d remove",
			cmd_seen[CMD_PUT], updates_seen, cmd_seen[CMD_POP], cmd_seen[CMD_PEEK],
			cmd_seen[CMD_DROP]);
		$display("status: %0d ok, %0d empty, %0d full, %0d bad handle; %0d results checked",
			stat_seen[STAT_OK], stat_seen[STAT_EMPTY], stat_seen[STAT_FULL],
			stat_seen[STAT_BAD], checked);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
